[rtl/pie_drop_probability_controller_assert.svh]
// Assertion macros shared by the PIE drop probability controller modules.
// No dependencies; included inside module bodies.
`ifndef PIE_DROP_PROBABILITY_CONTROLLER_ASSERT_SVH
`define PIE_DROP_PROBABILITY_CONTROLLER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/pie_pkg.sv]
// Types and constants of the PIE drop probability controller.
// No dependencies.
package pie_pkg;

	typedef struct packed {
		logic        kind;
		logic [31:0] now_ms;
		logic [23:0] queue_bytes;
		logic [15:0] packet_bytes;
	} pie_in_t;

	typedef struct packed {
		logic [24:0] drop_probability;
		logic [15:0] queue_delay_ms;
		logic [23:0] departure_rate;
		logic [15:0] burst_left_ms;
	} pie_out_t;

	localparam logic [2:0] REG_TARGET    = 3'd0;
	localparam logic [2:0] REG_MAX_BURST = 3'd1;
	localparam logic [2:0] REG_PERIOD    = 3'd2;
	localparam logic [2:0] REG_THRESH    = 3'd3;
	localparam logic [2:0] REG_ALPHA     = 3'd4;
	localparam logic [2:0] REG_BETA      = 3'd5;

	localparam logic        KIND_DEQ  = 1'b0;
	localparam logic        KIND_TICK = 1'b1;

	localparam logic [24:0] Q24_ONE       = 25'd16777216;
	localparam logic [24:0] PROB_LOW_EDGE = 25'd167773;
	localparam logic [24:0] PROB_MID_EDGE = 25'd1677722;
	localparam logic [15:0] DECAY_NUM     = 16'd64225;
	localparam logic [24:0] BYTES_MAX     = 25'h1FFFFFF;
	localparam logic [23:0] RATE_MAX      = 24'hFFFFFF;
	localparam logic [15:0] DELAY_MAX     = 16'hFFFF;
	localparam int          DIV_W         = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input item
		logic div_start; // start a division
		logic div_sel;   // 0: bytes / elapsed, 1: queue / rate
		logic deq_fin;   // finish a dequeue update
		logic tick_mul;  // register the gain products
		logic tick_fin;  // finish a tick update
	} pie_cmd_t;

	typedef struct packed {
		logic kind;
		logic need_div;  // dequeue that takes a rate sample
		logic rate_nz;
		logic div_done;
	} pie_sts_t;

endpackage

[rtl/pie_drop_probability_controller.sv]
// Top level of the PIE drop probability controller.
// Depends on pie_pkg, pie_ctrl, pie_datapath.
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  pie_in_t
//   out      output     out_valid/out_ready pie_out_t
//   cfg      input      cfg_we             cfg_index, cfg_data
// A dequeue transaction without a rate sample steps through decode and finish before
// its result is shown; a tick without a delay division steps through decode, gain
// products and finish. A division adds a pass through the one-bit-per-cycle 32-bit divider.
// The next input transaction is taken the cycle after the result is delivered.
// Reset is asynchronous and restores register defaults and zero state.
// A stalled output holds the result and keeps in_ready low.
module pie_drop_probability_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pie_pkg::pie_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pie_pkg::pie_out_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [23:0]       cfg_data
);
	import pie_pkg::*;

	pie_cmd_t cmd;
	pie_sts_t sts;

	pie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	pie_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_data), .cmd(cmd), .sts(sts), .result(out_data)
	);
endmodule

[rtl/pie_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pie_pkg.
module pie_divider (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pie_pkg::DIV_W-1:0] dividend,
	input  logic [pie_pkg::DIV_W-1:0] divisor,
	output logic                     done,
	output logic [pie_pkg::DIV_W-1:0] quotient
);
	import pie_pkg::*;

	logic [DIV_W-1:0] rem_q, quo_q, dvs_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   shifted;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

[rtl/pie_datapath.sv]
// Datapath: configuration, controller state, measurement and tick update.
// Depends on pie_pkg and pie_divider.
module pie_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	input  pie_pkg::pie_in_t  in_item,
	input  pie_pkg::pie_cmd_t cmd,
	output pie_pkg::pie_sts_t sts,
	output pie_pkg::pie_out_t result
);
	import pie_pkg::*;

	logic [15:0] target_q, max_burst_q;
	logic [9:0]  period_q;
	logic [23:0] thresh_q;
	logic [11:0] alpha_q, beta_q;

	logic [24:0] prob_q;
	logic [15:0] dnow_q, dbef_q;
	logic        meas_q;
	logic [24:0] mbytes_q;
	logic [31:0] mstart_q;
	logic [23:0] rate_q;
	logic [15:0] burst_q;

	pie_in_t     item_q;
	logic        meas_n;
	logic [24:0] mbytes_n;
	logic [31:0] mstart_n;
	logic [31:0] dt_q;

	logic        div_done;
	logic [31:0] div_quo, div_a, div_b;

	// Dequeue front half, evaluated on the captured item.
	logic        start_meas;
	logic [25:0] acc;
	logic [24:0] acc_sat;
	logic [31:0] dt_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= 16'd15;
			max_burst_q <= 16'd150;
			period_q    <= 10'd10;
			thresh_q    <= 24'd16384;
			alpha_q     <= 12'd32;
			beta_q      <= 12'd320;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET:    target_q    <= cfg_data[15:0];
				REG_MAX_BURST: max_burst_q <= cfg_data[15:0];
				REG_PERIOD:    period_q    <= cfg_data[9:0];
				REG_THRESH:    thresh_q    <= cfg_data;
				REG_ALPHA:     alpha_q     <= cfg_data[11:0];
				REG_BETA:      beta_q      <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
	end

	always_comb begin
		start_meas = (item_q.queue_bytes >= thresh_q) && !meas_q;
		meas_n   = meas_q | start_meas;
		mstart_n = start_meas ? item_q.now_ms : mstart_q;
		acc      = {1'b0, (start_meas ? 25'd0 : mbytes_q)} + 26'(item_q.packet_bytes);
		acc_sat  = acc[25] ? BYTES_MAX : acc[24:0];
		mbytes_n = acc_sat;
		dt_w     = item_q.now_ms - mstart_n;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) dt_q <= '0;
		else if (cmd.div_start) dt_q <= dt_w;
	end

	assign div_a = cmd.div_sel ? {8'd0, item_q.queue_bytes} : {7'd0, mbytes_n};
	assign div_b = cmd.div_sel ? {8'd0, rate_q} : dt_w;

	pie_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_quo)
	);

	// Rate sample and moving average.
	logic [23:0] sample;
	logic [24:0] avg;
	always_comb begin
		sample = (div_quo > 32'(RATE_MAX)) ? RATE_MAX : div_quo[23:0];
		if (rate_q == 24'd0) avg = {1'b0, sample};
		else avg = {1'b0, rate_q - (rate_q >> 3)} + {4'd0, sample[23:3]};
	end

	// Tick: delay, gain products (registered), then step and clamp.
	logic [15:0] d_new;
	logic signed [17:0] err_t, err_p;
	logic signed [30:0] pa_s1, pb_s1;
	logic [15:0]        dnew_s1;
	logic               decay_ok_s1;
	always_comb begin
		if (rate_q == 24'd0) d_new = 16'd0;
		else d_new = (div_quo > 32'(DELAY_MAX)) ? DELAY_MAX : div_quo[15:0];
		err_t = $signed({2'b0, d_new}) - $signed({2'b0, target_q});
		err_p = $signed({2'b0, d_new}) - $signed({2'b0, dnow_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_mul) begin
			pa_s1       <= $signed({1'b0, alpha_q}) * err_t;
			pb_s1       <= $signed({1'b0, beta_q}) * err_p;
			dnew_s1     <= d_new;
			decay_ok_s1 <= !(d_new == 16'd0 && item_q.queue_bytes != 24'd0);
		end
	end

	logic signed [31:0] sum;
	logic signed [44:0] step, prob_x;
	logic [24:0]        prob_c, prob_d;
	logic               allow;
	logic [40:0]        dec_prod;
	logic [15:0]        burst_t;
	always_comb begin
		sum = 32'(pa_s1) + 32'(pb_s1);
		if (prob_q < PROB_LOW_EDGE) step = 45'(sum) <<< 9;
		else if (prob_q < PROB_MID_EDGE) step = 45'(sum) <<< 11;
		else step = 45'(sum) <<< 12;
		prob_x = $signed({20'd0, prob_q}) + step;
		allow = decay_ok_s1;
		if (prob_x < 0) prob_c = '0;
		else if (prob_x > $signed({20'd0, Q24_ONE})) begin
			prob_c = Q24_ONE;
			allow  = 1'b0;
		end else prob_c = prob_x[24:0];
		dec_prod = prob_c * DECAY_NUM;
		if (dnew_s1 == 16'd0 && dnow_q == 16'd0 && allow) prob_d = dec_prod[40:16];
		else prob_d = prob_c;
		burst_t = (burst_q > {6'd0, period_q}) ? burst_q - {6'd0, period_q} : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_q   <= '0;
			dnow_q   <= '0;
			dbef_q   <= '0;
			meas_q   <= 1'b0;
			mbytes_q <= '0;
			mstart_q <= '0;
			rate_q   <= '0;
			burst_q  <= '0;
		end else if (cmd.deq_fin) begin
			meas_q   <= meas_n;
			mbytes_q <= mbytes_n;
			mstart_q <= mstart_n;
			if (sts.need_div) begin
				rate_q <= avg[24] ? RATE_MAX : avg[23:0];
				if (item_q.queue_bytes < thresh_q) meas_q <= 1'b0;
				else begin
					mbytes_q <= '0;
					mstart_q <= item_q.now_ms;
				end
				burst_q <= (32'(burst_q) > dt_q) ? burst_q - dt_q[15:0] : 16'd0;
			end
		end else if (cmd.tick_fin) begin
			dbef_q  <= dnow_q;
			dnow_q  <= dnew_s1;
			prob_q  <= prob_d;
			burst_q <= burst_t;
			if (prob_d == '0 && dnew_s1 < (target_q >> 1) && dnow_q < (target_q >> 1)
					&& rate_q != 24'd0) begin
				meas_q  <= 1'b0;
				rate_q  <= '0;
				burst_q <= max_burst_q;
			end
		end
	end

	assign sts.kind     = item_q.kind;
	assign sts.need_div = meas_n && (mbytes_n > {1'b0, thresh_q}) && (dt_w != 32'd0);
	assign sts.rate_nz  = rate_q != 24'd0;
	assign sts.div_done = div_done;

	assign result.drop_probability = prob_q;
	assign result.queue_delay_ms   = dnow_q;
	assign result.departure_rate   = rate_q;
	assign result.burst_left_ms    = burst_q;

	`include "pie_drop_probability_controller_assert.svh"
	`PIE_ASSERT_IMP(a_prob_range, clk, arst_n, 1'b1, prob_q <= Q24_ONE)
	`PIE_ASSERT_IMP(a_one_update, clk, arst_n, 1'b1, !(cmd.deq_fin && cmd.tick_fin))
	`PIE_ASSERT_NEXT(a_idle_clear, clk, arst_n, cmd.tick_fin && prob_d == '0 && dnew_s1 < (target_q >> 1) && dnow_q < (target_q >> 1), rate_q == 24'd0)
endmodule

[rtl/pie_ctrl.sv]
// Controller state machine sequencing loads, divisions and updates.
// Depends on pie_pkg.
module pie_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pie_pkg::pie_sts_t sts,
	output pie_pkg::pie_cmd_t cmd
);
	import pie_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_DECODE, ST_DIV, ST_MUL, ST_FIN, ST_OUT} state_t;
	state_t state_q;
	logic   tick_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load    = in_valid && in_ready;
		// The captured item's kind is valid from the decode cycle on.
		cmd.div_sel = sts.kind;
		case (state_q)
			ST_DECODE: cmd.div_start = (sts.kind == KIND_TICK) ? sts.rate_nz : sts.need_div;
			ST_MUL:    cmd.tick_mul  = 1'b1;
			ST_FIN: begin
				cmd.deq_fin  = !tick_q;
				cmd.tick_fin = tick_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tick_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DECODE;
				ST_DECODE: begin
					tick_q <= sts.kind;
					if (cmd.div_start) state_q <= ST_DIV;
					else state_q <= (sts.kind == KIND_TICK) ? ST_MUL : ST_FIN;
				end
				ST_DIV: if (sts.div_done) state_q <= tick_q ? ST_MUL : ST_FIN;
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: begin
					state_q   <= ST_OUT;
					out_valid <= 1'b1;
				end
				ST_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "pie_drop_probability_controller_assert.svh"
	`PIE_ASSERT_IMP(a_out_in_out, clk, arst_n, out_valid, state_q == ST_OUT)
	`PIE_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !in_ready)
	`PIE_ASSERT_NEXT(a_fin_once, clk, arst_n, state_q == ST_FIN, state_q == ST_OUT)
endmodule

[dv/pie_drop_probability_checker.sv]
// Watches the channels of the PIE drop probability controller, predicts each result
// and compares it field by field. Depends on pie_pkg.
module pie_drop_probability_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  pie_pkg::pie_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  pie_pkg::pie_out_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	output int                fail_count,
	output int                pending
);
	import pie_pkg::*;

	logic [15:0] target_ms, burst_max_ms, burst_ms, dly_now, dly_prev;
	logic [9:0]  period_ms;
	logic [23:0] thresh_bytes, rate_avg;
	logic [11:0] alpha_q8, beta_q8;
	logic [24:0] prob_q24, byte_count;
	logic [31:0] start_ms;
	logic        in_measure;
	pie_out_t    result_queue[$];

	function automatic logic [15:0] sub_floor(logic [15:0] a, logic [31:0] b);
		return ({16'd0, a} > b) ? a - b[15:0] : 16'd0;
	endfunction

	task automatic advance_dequeue(pie_in_t it);
		logic [31:0] dt;
		longint sample, avg;
		if (it.queue_bytes >= thresh_bytes && !in_measure) begin
			start_ms = it.now_ms;
			byte_count = '0;
			in_measure = 1'b1;
		end
		if (!in_measure) return;
		byte_count = ({1'b0, byte_count} + it.packet_bytes > BYTES_MAX) ? BYTES_MAX
			: byte_count + it.packet_bytes;
		if (byte_count > thresh_bytes) begin
			dt = it.now_ms - start_ms;
			if (dt != 0) begin
				sample = byte_count / dt;
				if (sample > RATE_MAX) sample = RATE_MAX;
				if (rate_avg == 0) avg = sample;
				else avg = rate_avg - (rate_avg >> 3) + (sample >> 3);
				rate_avg = (avg > RATE_MAX) ? RATE_MAX : avg[23:0];
				if (it.queue_bytes < thresh_bytes) begin
					in_measure = 1'b0;
				end else begin
					byte_count = '0;
					start_ms = it.now_ms;
				end
				burst_ms = sub_floor(burst_ms, dt);
			end
		end
	endtask

	task automatic advance_tick(pie_in_t it);
		logic decay_ok;
		longint d, sum, nextp;
		decay_ok = 1'b1;
		dly_prev = dly_now;
		if (rate_avg != 0) begin
			d = it.queue_bytes / rate_avg;
			dly_now = (d > DELAY_MAX) ? DELAY_MAX : d[15:0];
		end else begin
			dly_now = '0;
		end
		if (dly_now == 0 && it.queue_bytes != 0) decay_ok = 1'b0;
		sum = longint'(alpha_q8) * (longint'(dly_now) - longint'(target_ms))
			+ longint'(beta_q8) * (longint'(dly_now) - longint'(dly_prev));
		if (prob_q24 < PROB_LOW_EDGE) nextp = prob_q24 + sum * 512;
		else if (prob_q24 < PROB_MID_EDGE) nextp = prob_q24 + sum * 2048;
		else nextp = prob_q24 + sum * 4096;
		if (nextp < 0) begin
			nextp = 0;
		end else if (nextp > Q24_ONE) begin
			nextp = Q24_ONE;
			decay_ok = 1'b0;
		end
		prob_q24 = nextp[24:0];
		if (dly_now == 0 && dly_prev == 0 && decay_ok)
			prob_q24 = 25'((longint'(prob_q24) * DECAY_NUM) >> 16);
		burst_ms = sub_floor(burst_ms, 32'(period_ms));
		if (prob_q24 == 0 && dly_now < target_ms / 2 && dly_prev < target_ms / 2
			&& rate_avg != 0) begin
			in_measure = 1'b0;
			rate_avg = '0;
			burst_ms = burst_max_ms;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pie_out_t want;
		if (!arst_n) begin
			target_ms = 16'd15; burst_max_ms = 16'd150; period_ms = 10'd10;
			thresh_bytes = 24'd16384; alpha_q8 = 12'd32; beta_q8 = 12'd320;
			prob_q24 = '0; dly_now = '0; dly_prev = '0; in_measure = 1'b0;
			byte_count = '0; start_ms = '0; rate_avg = '0; burst_ms = '0;
			result_queue.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result %h", out_data);
				end else begin
					want = result_queue.pop_front();
					if (want !== out_data) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: prob %0d/%0d delay %0d/%0d rate %0d/%0d burst %0d/%0d",
								want.drop_probability, out_data.drop_probability,
								want.queue_delay_ms, out_data.queue_delay_ms,
								want.departure_rate, out_data.departure_rate,
								want.burst_left_ms, out_data.burst_left_ms);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.kind == KIND_TICK) advance_tick(in_data);
				else advance_dequeue(in_data);
				want.drop_probability = prob_q24;
				want.queue_delay_ms = dly_now;
				want.departure_rate = rate_avg;
				want.burst_left_ms = burst_ms;
				result_queue.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET:    target_ms = cfg_data[15:0];
					REG_MAX_BURST: burst_max_ms = cfg_data[15:0];
					REG_PERIOD:    period_ms = cfg_data[9:0];
					REG_THRESH:    thresh_bytes = cfg_data;
					REG_ALPHA:     alpha_q8 = cfg_data[11:0];
					REG_BETA:      beta_q8 = cfg_data[11:0];
					default:       ;
				endcase
			end
			pending = result_queue.size();
		end
	end
endmodule

[dv/pie_drop_probability_controller_tb.sv]
// Testbench top of the PIE drop probability controller: clock, reset, stimulus,
// configuration phases and verdict. Depends on pie_pkg and pie_drop_probability_checker.
module pie_drop_probability_controller_tb;
	import pie_pkg::*;

	logic       clk = 1'b0, arst_n = 1'b0;
	logic       in_valid = 1'b0, out_ready = 1'b0, cfg_we = 1'b0;
	pie_in_t    in_data = '0;
	logic [2:0] cfg_index = REG_TARGET;
	logic [23:0] cfg_data = '0;
	logic       in_ready, out_valid;
	pie_out_t   out_data;
	int         fail_count, pending;
	logic       calm = 1'b0, hold_off = 1'b0;
	logic [31:0] clock_ms = '0;
	logic [23:0] q_level = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pie_drop_probability_controller u_top (.*);
	pie_drop_probability_checker u_chk (.*);

	// Receiver: random stalls, none while calm, a long blockade when asked.
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else if (hold_off) out_ready <= 1'b0;
		else out_ready <= calm || ($urandom_range(99) >= 36);
	end

	// The caller drops cfg_we after its last write.
	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic drain_out;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Valid stays up after acceptance until the next idle cycle or the next item.
	task automatic send_item(pie_in_t it);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1; in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// A random stream: time advances with occasional jumps, queue drifts, ticks interleave.
	function automatic pie_in_t make_item();
		pie_in_t it;
		int r;
		r = $urandom_range(99);
		it.kind = (r < 30) ? KIND_TICK : KIND_DEQ;
		clock_ms = clock_ms + $urandom_range(3);
		if (r >= 95) clock_ms = $urandom;
		if ($urandom_range(9) == 0) q_level = $urandom_range(3) == 0 ? 24'd0 : 24'($urandom);
		else q_level = 24'(q_level + $urandom_range(3000) - 1500);
		it.now_ms = clock_ms;
		it.queue_bytes = q_level;
		it.packet_bytes = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
		return it;
	endfunction

	initial begin
		#400000000;
		$display("pie_drop_probability_controller_tb NOT OK");
		$finish;
	end

	initial begin
		pie_in_t it;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: extremes, zero rate, clamps, time wrap, large values.
		it = '{KIND_TICK, 32'd0, 24'd0, 16'd0};             send_item(it);
		it = '{KIND_TICK, 32'd0, 24'd5000, 16'd0};          send_item(it);
		it = '{KIND_DEQ, 32'hFFFFFFFE, 24'hFFFFFF, 16'hFFFF}; send_item(it);
		it = '{KIND_DEQ, 32'hFFFFFFFE, 24'hFFFFFF, 16'hFFFF}; send_item(it);
		it = '{KIND_DEQ, 32'd3, 24'hFFFFFF, 16'hFFFF};      send_item(it);
		it = '{KIND_DEQ, 32'd4, 24'd20000, 16'd1500};       send_item(it);
		it = '{KIND_TICK, 32'd4, 24'hFFFFFF, 16'hFFFF};     send_item(it);
		it = '{KIND_TICK, 32'd5, 24'hFFFFFF, 16'd0};        send_item(it);
		it = '{KIND_TICK, 32'd6, 24'd0, 16'd0};             send_item(it);
		it = '{KIND_TICK, 32'd7, 24'd0, 16'd0};             send_item(it);
		it = '{KIND_TICK, 32'd8, 24'd0, 16'd0};             send_item(it);
		drain_out();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_TARGET, 24'd1); write_reg(REG_MAX_BURST, 24'd1);
					write_reg(REG_PERIOD, 24'd1); write_reg(REG_THRESH, 24'd1);
					write_reg(REG_ALPHA, 24'd0); write_reg(REG_BETA, 24'd0);
				end
				1: begin
					write_reg(REG_TARGET, 24'hFFFFFF); write_reg(REG_MAX_BURST, 24'hFFFF);
					write_reg(REG_PERIOD, 24'd1000); write_reg(REG_THRESH, 24'hFFFFFF);
					write_reg(REG_ALPHA, 24'd4095); write_reg(REG_BETA, 24'd4095);
				end
				2: begin
					write_reg(REG_TARGET, 24'd15); write_reg(REG_MAX_BURST, 24'd150);
					write_reg(REG_PERIOD, 24'd10); write_reg(REG_THRESH, 24'd16384);
					write_reg(REG_ALPHA, 24'd32); write_reg(REG_BETA, 24'd320);
				end
				default: begin
					write_reg(REG_TARGET, 24'($urandom_range(40, 1)));
					write_reg(REG_MAX_BURST, 24'($urandom));
					write_reg(REG_PERIOD, 24'($urandom));
					write_reg(REG_THRESH, 24'($urandom_range(30000, 1)));
					write_reg(REG_ALPHA, 24'($urandom));
					write_reg(REG_BETA, 24'($urandom));
				end
			endcase
			cfg_we <= 1'b0;
			calm <= (phase == 3);
			for (int n = 0; n < 100; n++) begin
				if (phase == 4 && n == 20) begin
					// Long receiver blockade while items keep being offered.
					hold_off <= 1'b1;
					fork
						begin
							repeat (300) @(posedge clk);
							hold_off <= 1'b0;
						end
					join_none
				end
				if (n == 50) drain_out();
				send_item(make_item());
			end
			drain_out();
		end
		if (fail_count == 0)
			$display("pie_drop_probability_controller_tb OK");
		else
			$display("pie_drop_probability_controller_tb NOT OK");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/pie_pkg.sv
rtl/pie_divider.sv
rtl/pie_datapath.sv
rtl/pie_ctrl.sv
rtl/pie_drop_probability_controller.sv
dv/pie_drop_probability_checker.sv
dv/pie_drop_probability_controller_tb.sv
